@@ rtl/core/mdfc_pkg.sv @@
// ----------------------------------------------------------------------------
// mdfc_pkg: shared types and constants
// Widths, verdict codes, register indexes and the controller/datapath
// command and status bundles of the multicast duplicate filter cache.
// ----------------------------------------------------------------------------
package mdfc_pkg;

	localparam int CACHE_ENTRIES = 8;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	localparam int SID_W = 16;
	localparam int SUBNET_W = 16;
	localparam int SEQ_W = 8;
	localparam int LIFE_W = 4;
	localparam int CNT_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_OWN    = 2'd1,
		VERDICT_STALE  = 2'd2,
		VERDICT_FULL   = 2'd3
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCAL_SID     = 3'd0,
		CFG_SUBNET_A      = 3'd1,
		CFG_SUBNET_B      = 3'd2,
		CFG_SUBNET_COUNT  = 3'd3,
		CFG_LIFETIME      = 3'd4
	} cfg_reg_t;

	localparam logic [CNT_W-1:0] SUBNET_COUNT_RST = 2'd1;
	localparam logic [LIFE_W-1:0] LIFETIME_RST = 4'd10;

	typedef struct packed {
		logic load;        // capture the accepted word
		logic age;         // count every live lifetime down
		logic scan_clear;  // start a scan at entry zero
		logic scan_step;   // examine the current entry, advance
		logic set_own;
		logic set_full;
		logic write_entry; // rewrite the chosen entry
		logic push_out;    // load the result register
	} mdfc_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic is_own;
		logic entry_free;
		logic entry_hit;
		logic idx_last;
		logic have_chosen;
		logic out_free;
	} mdfc_sts_t;

endpackage

@@ rtl/core/mdfc_if.sv @@
// ----------------------------------------------------------------------------
// mdfc_if: channel interfaces
// Valid/ready channels for header/tick words and for verdict words.
// ----------------------------------------------------------------------------
interface mdfc_req_if
	import mdfc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [SID_W-1:0]    sender_sid;
	logic [SUBNET_W-1:0] sender_subnet;
	logic [SEQ_W-1:0]    seq_number;

	modport source (output valid, kind, sender_sid, sender_subnet, seq_number, input ready);
	modport sink (input valid, kind, sender_sid, sender_subnet, seq_number, output ready);
endinterface

interface mdfc_rsp_if
	import mdfc_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

@@ rtl/core/mcast_duplicate_filter_cache_top.sv @@
// ----------------------------------------------------------------------------
// mcast_duplicate_filter_cache_top: multicast duplicate filter cache
// Screens multicast headers against a table of recently seen senders and
// ages the table on tick words.
// ----------------------------------------------------------------------------
// Channels: req carries one word per header check (kind 0) or ageing tick
// (kind 1); rsp carries one verdict word per header check, none per tick.
// Verdicts: accept, drop own packet, drop stale or repeat, drop table full.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// write only while the block is idle.
// Timing: one word is in work at a time. A tick returns to accept once
// the table is aged. A header from the node itself skips the scan and
// goes straight to the output. Any other header is screened by a scan
// over the table, one entry per cycle, and a rewrite of the chosen entry;
// a hit stops the scan early, a full table skips the rewrite cycle.
// req.ready returns in the same cycle the verdict appears.
// Stall: the verdict sits in an output register, so req is accepted again
// while rsp waits; a second verdict waits in the controller until the
// register frees.
// Reset: arst_n clears the configuration to its defaults (subnet count one,
// lifetime ten) and marks every entry free at once; no clearing pass.
// ----------------------------------------------------------------------------
module mcast_duplicate_filter_cache_top
	import mdfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	mdfc_req_if.sink              req,
	mdfc_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mdfc_cmd_t cmd;
	mdfc_sts_t sts;

	// sequencing: accept, own check, scan, rewrite, hand off
	mdfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table, configuration and output register
	mdfc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_kind     (req.kind),
		.in_sid      (req.sender_sid),
		.in_subnet   (req.sender_subnet),
		.in_seq      (req.seq_number),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_verdict (rsp.verdict),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

@@ rtl/core/mdfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mdfc_ctrl: sequencing state machine
// Accepts one word, checks own packets, scans the table one entry per
// cycle, rewrites the chosen entry and hands the verdict to the output.
// ----------------------------------------------------------------------------
module mdfc_ctrl
	import mdfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  mdfc_sts_t sts,
	output mdfc_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.is_tick) begin
					cmd.age = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.is_own) begin
					cmd.set_own = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.scan_clear = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.entry_hit) begin
					state_d = ST_WRITE;
				end else if (sts.idx_last) begin
					if (sts.have_chosen) begin
						state_d = ST_WRITE;
					end else begin
						cmd.set_full = 1'b1;
						state_d      = ST_DONE;
					end
				end
			end
			ST_WRITE: begin
				cmd.write_entry = 1'b1;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				// hold until the result register can take the word
				if (sts.out_free) begin
					cmd.push_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/mdfc_dp.sv @@
// ----------------------------------------------------------------------------
// mdfc_dp: datapath
// Configuration registers, entry table, scan pointer, verdict and the
// output register.
// ----------------------------------------------------------------------------
module mdfc_dp
	import mdfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_kind,
	input  logic [SID_W-1:0]      in_sid,
	input  logic [SUBNET_W-1:0]   in_subnet,
	input  logic [SEQ_W-1:0]      in_seq,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            out_verdict,
	input  mdfc_cmd_t             cmd,
	output mdfc_sts_t             sts
);

	logic [SID_W-1:0]    local_sid_q;
	logic [SUBNET_W-1:0] subnet_a_q;
	logic [SUBNET_W-1:0] subnet_b_q;
	logic [CNT_W-1:0]    subnet_cnt_q;
	logic [LIFE_W-1:0]   lifetime_q;

	logic                kind_q;
	logic [SID_W-1:0]    sid_q;
	logic [SUBNET_W-1:0] subnet_q;
	logic [SEQ_W-1:0]    seq_q;

	logic [SID_W-1:0]    ent_sid_q    [CACHE_ENTRIES];
	logic [SUBNET_W-1:0] ent_subnet_q [CACHE_ENTRIES];
	logic [SEQ_W-1:0]    ent_seq_q    [CACHE_ENTRIES];
	logic [LIFE_W-1:0]   ent_life_q   [CACHE_ENTRIES];

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] chosen_q;
	logic             chosen_v_q;
	verdict_t         verdict_q;
	logic             out_valid_q;
	verdict_t         out_verdict_q;

	logic [SEQ_W-1:0] seq_diff;
	logic             stale;
	logic             subnet_local;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_sid_q  <= '0;
			subnet_a_q   <= '0;
			subnet_b_q   <= '0;
			subnet_cnt_q <= SUBNET_COUNT_RST;
			lifetime_q   <= LIFETIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCAL_SID:    local_sid_q  <= cfg_data[SID_W-1:0];
				CFG_SUBNET_A:     subnet_a_q   <= cfg_data[SUBNET_W-1:0];
				CFG_SUBNET_B:     subnet_b_q   <= cfg_data[SUBNET_W-1:0];
				CFG_SUBNET_COUNT: subnet_cnt_q <= cfg_data[CNT_W-1:0];
				CFG_LIFETIME:     lifetime_q   <= cfg_data[LIFE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= in_kind;
			sid_q    <= in_sid;
			subnet_q <= in_subnet;
			seq_q    <= in_seq;
		end
	end

	// count of three behaves as two: only bit 1 and a nonzero count matter
	assign subnet_local = ((subnet_cnt_q != '0) && (subnet_q == subnet_a_q)) ||
		(subnet_cnt_q[1] && (subnet_q == subnet_b_q));

	assign seq_diff = seq_q - ent_seq_q[idx_q];
	assign stale    = (seq_diff == '0) || seq_diff[SEQ_W-1];

	always_comb begin
		sts.is_tick     = kind_q;
		sts.is_own      = (sid_q == local_sid_q) && subnet_local;
		sts.entry_free  = (ent_life_q[idx_q] == '0);
		sts.entry_hit   = !sts.entry_free && (ent_sid_q[idx_q] == sid_q) &&
			(ent_subnet_q[idx_q] == subnet_q);
		sts.idx_last    = (idx_q == IDX_W'(CACHE_ENTRIES - 1));
		sts.have_chosen = chosen_v_q || sts.entry_free;
		sts.out_free    = !out_valid_q || out_ready;
	end

	// scan pointer and chosen entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			chosen_v_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			idx_q      <= '0;
			chosen_v_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (sts.entry_free || sts.entry_hit) begin
				chosen_v_q <= 1'b1;
			end
			if (!sts.idx_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && (sts.entry_free || sts.entry_hit)) begin
			chosen_q <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.scan_clear) begin
			verdict_q <= VERDICT_ACCEPT;
		end else if (cmd.set_own) begin
			verdict_q <= VERDICT_OWN;
		end else if (cmd.set_full) begin
			verdict_q <= VERDICT_FULL;
		end else if (cmd.scan_step && sts.entry_hit) begin
			verdict_q <= stale ? VERDICT_STALE : VERDICT_ACCEPT;
		end else begin
			verdict_q <= verdict_q;
		end
	end

	// entry payload, undefined until written
	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			ent_sid_q[chosen_q]    <= sid_q;
			ent_subnet_q[chosen_q] <= subnet_q;
			ent_seq_q[chosen_q]    <= seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				ent_life_q[i] <= '0;
			end
		end else if (cmd.age) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				if (ent_life_q[i] != '0) begin
					ent_life_q[i] <= ent_life_q[i] - LIFE_W'(1);
				end
			end
		end else if (cmd.write_entry) begin
			ent_life_q[chosen_q] <= lifetime_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_out) begin
			out_verdict_q <= verdict_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_verdict = out_verdict_q;

endmodule

@@ rtl/core/mdfc_chk.sv @@
// ----------------------------------------------------------------------------
// mdfc_chk: port checker
// Watches the channels of the filter cache top level over time.
// ----------------------------------------------------------------------------
module mdfc_chk
	import mdfc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       req_kind,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_verdict
);

	// a verdict word holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("verdict word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_verdict))
		else $error("verdict changed while stalled");

	// one word in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second word accepted while one is in work");

	// a tick gives no verdict
	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
		else $error("tick produced a verdict");

endmodule

bind mcast_duplicate_filter_cache_top mdfc_chk u_mdfc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_kind    (req.kind),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_verdict (rsp.verdict)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: multicast duplicate filter cache testbench
// Drives header and tick words into the cache, keeps its own copy of the
// sender table and the local registers, and checks every verdict word in
// order. A short directed table opens the run; random words follow under
// six register settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import mdfc_pkg::*;

	// Run shape: six settings (reset defaults plus five written ones), each
	// followed by a stretch of random words.
	localparam int NUM_SETTINGS    = 5;
	localparam int WORDS_PER_PHASE = 222;
	localparam int POOL_SIZE       = 10;
	// Longest header scan plus margin; a tick gives no verdict to wait for.
	localparam int SETTLE_CYCLES   = 4 + CACHE_ENTRIES + 8;
	// Bound on the whole run, several times the slowest correct run.
	localparam int CYCLE_LIMIT     = 400000;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic                kind;
		logic [SID_W-1:0]    sid;
		logic [SUBNET_W-1:0] subnet;
		logic [SEQ_W-1:0]    seq;
	} hdr_word_t;

	// One row of the directed table: the word, and a verdict typed in by hand
	// where it is obvious; other rows take the predicted verdict.
	typedef struct packed {
		hdr_word_t w;
		logic      fixed;
		verdict_t  want;
	} hdr_row_t;

	typedef struct packed {
		logic [SID_W-1:0]    sid;
		logic [SUBNET_W-1:0] subnet_a;
		logic [SUBNET_W-1:0] subnet_b;
		logic [CNT_W-1:0]    subnet_count;
		logic [LIFE_W-1:0]   lifetime;
	} cfg_set_t;

	// Opens right after reset: local id 0, subnet a 0, one local subnet,
	// lifetime ten, empty table.
	localparam hdr_row_t DIRECTED [18] = '{
		// own packet: sender and subnet both local
		'{'{1'b0, 16'h0000, 16'h0000, 8'h00}, 1'b1, VERDICT_OWN},
		// same id on a foreign subnet lands in the top free entry
		'{'{1'b0, 16'h0000, 16'h0001, 8'h00}, 1'b1, VERDICT_ACCEPT},
		// exact repeat
		'{'{1'b0, 16'h0000, 16'h0001, 8'h00}, 1'b1, VERDICT_STALE},
		// step forward, then jumps around the signed half-range edge
		'{'{1'b0, 16'h0000, 16'h0001, 8'h01}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'h0000, 16'h0001, 8'h81}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'h0000, 16'h0001, 8'h00}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'h0000, 16'h0001, 8'hFF}, 1'b0, VERDICT_ACCEPT},
		// fill the rest of the table with field extremes
		'{'{1'b0, 16'h0001, 16'h0000, 8'h7F}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'hFFFF, 16'h0000, 8'h00}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'h0000, 16'hFFFF, 8'h80}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'h8000, 16'h0001, 8'h55}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'h0001, 16'h8000, 8'hAA}, 1'b0, VERDICT_ACCEPT},
		'{'{1'b0, 16'h5555, 16'hAAAA, 8'h01}, 1'b0, VERDICT_ACCEPT},
		// every entry live, new sender: table full, nothing written
		'{'{1'b0, 16'hAAAA, 16'h5555, 8'h02}, 1'b1, VERDICT_FULL},
		// tick with every payload bit set; the payload is ignored
		'{'{1'b1, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, VERDICT_ACCEPT},
		// sequence wrap from 0xFF to 0x00 counts as ahead
		'{'{1'b0, 16'hFFFF, 16'hFFFF, 8'h00}, 1'b0, VERDICT_ACCEPT},
		// one tick is far from freeing anything
		'{'{1'b0, 16'h1234, 16'h5678, 8'h00}, 1'b1, VERDICT_FULL}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic calm;

	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mdfc_req_if req_ch ();
	mdfc_rsp_if rsp_ch ();

	mcast_duplicate_filter_cache_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: sender table and local registers
	// ------------------------------------------------------------------
	logic [SID_W-1:0]    cache_sid    [CACHE_ENTRIES];
	logic [SUBNET_W-1:0] cache_subnet [CACHE_ENTRIES];
	logic [SEQ_W-1:0]    cache_seq    [CACHE_ENTRIES];
	logic [LIFE_W-1:0]   cache_life   [CACHE_ENTRIES];

	logic [SID_W-1:0]    own_sid;
	logic [SUBNET_W-1:0] own_subnet_a;
	logic [SUBNET_W-1:0] own_subnet_b;
	logic [CNT_W-1:0]    own_subnet_count;
	logic [LIFE_W-1:0]   fresh_lifetime;

	verdict_t pending_verdicts [$];

	int error_count;
	int headers_sent;
	int ticks_sent;
	int settings_used;
	int cycle_count;
	int verdict_tally [4];

	function automatic logic subnet_is_own(input logic [SUBNET_W-1:0] subnet);
		// a count of three behaves as two
		return (own_subnet_count >= 2'd1 && subnet == own_subnet_a) ||
		       (own_subnet_count >= 2'd2 && subnet == own_subnet_b);
	endfunction

	// Screen one header against the table and update the table as the block
	// does: the first live match decides, else the highest free entry is taken.
	function automatic verdict_t screen_header(input logic [SID_W-1:0] sid,
	                                           input logic [SUBNET_W-1:0] subnet,
	                                           input logic [SEQ_W-1:0] seq);
		int       chosen;
		int       i;
		logic     hit;
		logic [SEQ_W-1:0] ahead;
		verdict_t v;
		chosen = -1;
		hit = 1'b0;
		v = VERDICT_ACCEPT;
		if (sid == own_sid && subnet_is_own(subnet))
			return VERDICT_OWN;
		for (i = 0; i < CACHE_ENTRIES && !hit; i++) begin
			if (cache_life[i] == '0) begin
				chosen = i;
			end else if (cache_sid[i] == sid && cache_subnet[i] == subnet) begin
				// not ahead in signed 8-bit terms: zero or top bit set
				ahead = seq - cache_seq[i];
				if (ahead == '0 || ahead[SEQ_W-1])
					v = VERDICT_STALE;
				chosen = i;
				hit = 1'b1;
			end
		end
		if (chosen < 0)
			return VERDICT_FULL;
		// rewrite the chosen entry even on a stale drop
		cache_sid[chosen] = sid;
		cache_subnet[chosen] = subnet;
		cache_seq[chosen] = seq;
		cache_life[chosen] = fresh_lifetime;
		return v;
	endfunction

	function automatic void age_cache();
		int i;
		for (i = 0; i < CACHE_ENTRIES; i++)
			if (cache_life[i] != '0)
				cache_life[i] = cache_life[i] - LIFE_W'(1);
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// ------------------------------------------------------------------
	// Sender side. Called at a rising edge; returns at the edge where the
	// word is taken. Valid stays high between back-to-back words.
	// ------------------------------------------------------------------
	task automatic offer_word(input hdr_word_t w, input logic fixed, input verdict_t want);
		int gap;
		verdict_t v;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 15);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= w.kind;
		req_ch.sender_sid <= w.sid;
		req_ch.sender_subnet <= w.subnet;
		req_ch.seq_number <= w.seq;
		do @(posedge clk); while (!req_ch.ready);
		if (w.kind) begin
			age_cache();
			ticks_sent++;
		end else begin
			v = screen_header(w.sid, w.subnet, w.seq);
			pending_verdicts.push_back(fixed ? want : v);
			headers_sent++;
		end
	endtask

	// Drop valid, wait for every verdict, then let a trailing tick finish.
	task automatic settle_block();
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register on the next edge and mirror it in the predictor.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LOCAL_SID:    own_sid = value;
			CFG_SUBNET_A:     own_subnet_a = value;
			CFG_SUBNET_B:     own_subnet_b = value;
			CFG_SUBNET_COUNT: own_subnet_count = value[CNT_W-1:0];
			CFG_LIFETIME:     fresh_lifetime = value[LIFE_W-1:0];
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Receiver side: check each taken verdict word against the oldest
	// expectation, and stall ready in random bursts.
	// ------------------------------------------------------------------
	initial begin
		int       hold_left;
		verdict_t want;
		hold_left = 0;
		rsp_ch.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					flag_error($sformatf("verdict %0d with none expected", rsp_ch.verdict));
				end else begin
					want = pending_verdicts.pop_front();
					if (rsp_ch.verdict !== want)
						flag_error($sformatf("verdict expected %s, got %0d",
						                     want.name(), rsp_ch.verdict));
					else
						verdict_tally[int'(want)]++;
				end
			end
			// hold a stall until its burst runs out, then release
			if (hold_left > 0) begin
				hold_left--;
			end else if (!calm && rsp_ch.ready && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left = $urandom_range(1, 15) - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Cycle counter and run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d verdicts outstanding",
		         cycle_count, pending_verdicts.size());
		$display("tb_top NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_set_t            settings [NUM_SETTINGS];
		logic [SID_W-1:0]    pool_sid    [POOL_SIZE];
		logic [SUBNET_W-1:0] pool_subnet [POOL_SIZE];
		logic [SEQ_W-1:0]    pool_seq    [POOL_SIZE];
		hdr_word_t           w;
		int                  r;
		int                  phase;
		int                  n;
		int                  p;
		int                  pick;
		int                  i;

		// Drive every input from time zero; hold reset low.
		arst_n = 1'b0;
		calm = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LOCAL_SID;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = 1'b0;
		req_ch.sender_sid = '0;
		req_ch.sender_subnet = '0;
		req_ch.seq_number = '0;

		error_count = 0;
		headers_sent = 0;
		ticks_sent = 0;
		settings_used = 1;
		for (i = 0; i < 4; i++)
			verdict_tally[i] = 0;

		// Predictor after reset: every entry free, registers at defaults.
		for (i = 0; i < CACHE_ENTRIES; i++) begin
			cache_sid[i] = '0;
			cache_subnet[i] = '0;
			cache_seq[i] = '0;
			cache_life[i] = '0;
		end
		own_sid = '0;
		own_subnet_a = '0;
		own_subnet_b = '0;
		own_subnet_count = SUBNET_COUNT_RST;
		fresh_lifetime = LIFETIME_RST;

		// Settings to walk through: all-ones ids with lifetime 15, no local
		// subnet with lifetime 1, count three with all-ones b, lifetime zero
		// (written entries stay free), and back to the default lifetime.
		settings[0] = '{16'hFFFF, 16'hFFFF, 16'h0000, 2'd2, 4'd15};
		settings[1] = '{16'($urandom), 16'($urandom), 16'($urandom), 2'd0, 4'd1};
		settings[2] = '{16'h0000, 16'($urandom), 16'hFFFF, 2'd3, 4'd4};
		settings[3] = '{16'($urandom), 16'($urandom), 16'($urandom), 2'd1, 4'd0};
		settings[4] = '{16'($urandom), 16'h0000, 16'($urandom), 2'd2, LIFETIME_RST};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(DIRECTED); r++)
			offer_word(DIRECTED[r].w, DIRECTED[r].fixed, DIRECTED[r].want);

		for (phase = 0; phase <= NUM_SETTINGS; phase++) begin
			if (phase != 0) begin
				settle_block();
				write_reg(CFG_LOCAL_SID, settings[phase-1].sid);
				write_reg(CFG_SUBNET_A, settings[phase-1].subnet_a);
				write_reg(CFG_SUBNET_B, settings[phase-1].subnet_b);
				write_reg(CFG_SUBNET_COUNT, 16'(settings[phase-1].subnet_count));
				write_reg(CFG_LIFETIME, 16'(settings[phase-1].lifetime));
				settings_used++;
			end
			// last stretch runs without any idling
			if (phase == NUM_SETTINGS)
				calm = 1'b1;

			// Build a small sender pool so entries match, collide and fill:
			// some share the local id, some a local subnet, some a sender id.
			for (p = 0; p < POOL_SIZE; p++) begin
				case (p % 5)
					0: begin
						pool_sid[p] = own_sid;
						pool_subnet[p] = 16'($urandom);
					end
					1: begin
						pool_sid[p] = 16'($urandom);
						pool_subnet[p] = own_subnet_a;
					end
					2: begin
						pool_sid[p] = pool_sid[p-1];
						pool_subnet[p] = 16'($urandom);
					end
					default: begin
						pool_sid[p] = 16'($urandom);
						pool_subnet[p] = 16'($urandom);
					end
				endcase
				pool_seq[p] = 8'($urandom);
			end

			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				w.kind = 1'b0;
				w.sid = 16'($urandom);
				w.subnet = 16'($urandom);
				w.seq = 8'($urandom);
				if (pick < 10) begin
					// ageing tick with a random payload
					w.kind = 1'b1;
				end else if (pick < 16) begin
					// own-looking header on subnet a or subnet b
					w.sid = own_sid;
					w.subnet = ($urandom_range(0, 1) != 0) ? own_subnet_a : own_subnet_b;
				end else if (pick >= 26) begin
					// well-formed stream from a pool sender: mostly advancing,
					// some repeats, some jumps anywhere
					p = $urandom_range(0, POOL_SIZE - 1);
					w.sid = pool_sid[p];
					w.subnet = pool_subnet[p];
					pick = $urandom_range(0, 19);
					if (pick < 14)
						w.seq = pool_seq[p] + 8'($urandom_range(1, 4));
					else if (pick < 17)
						w.seq = pool_seq[p];
					pool_seq[p] = w.seq;
				end
				offer_word(w, 1'b0, VERDICT_ACCEPT);
			end
		end

		settle_block();
		if (pending_verdicts.size() != 0)
			flag_error("verdicts still expected at the end");

		$display("ran %0d header words and %0d ageing ticks under %0d register settings",
		         headers_sent, ticks_sent, settings_used);
		$display("verdicts matched: %0d accept, %0d own, %0d stale, %0d full; %0d errors",
		         verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
		         error_count);
		if (error_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/mdfc_pkg.sv
rtl/core/mdfc_if.sv
rtl/core/mdfc_ctrl.sv
rtl/core/mdfc_dp.sv
rtl/core/mcast_duplicate_filter_cache_top.sv
rtl/core/mdfc_chk.sv
test/tb_top.sv
